// ----- rtl/gne_pkg.sv -----
// gne_pkg: shared types, codes, move tables and helpers of the grid neighbour expander
// no dependencies; used by every file of the block but gne_map
package gne_pkg;

  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int NSLOT     = 8;

  localparam logic ACT_TOGGLE = 1'b0;
  localparam logic ACT_EXPAND = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_MODE   = 2'd2;

  localparam logic [DIM_W-1:0] GRID_DIM_RESET = 7'd64;
  localparam logic             MOVE_MODE_RESET = 1'b0;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } step_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             mode8;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               mode8;
    logic               odd;
    logic               now_blocked;
    logic               out_of_grid;
    logic [NSLOT-1:0]   open_mask;
  } job_t;

  localparam step_t ORDER_EVEN4 [4] = '{
    '{2'sd0, 2'sd1}, '{2'sd0, -2'sd1}, '{-2'sd1, 2'sd0}, '{2'sd1, 2'sd0}
  };
  localparam step_t ORDER_ODD4 [4] = '{
    '{2'sd1, 2'sd0}, '{-2'sd1, 2'sd0}, '{2'sd0, -2'sd1}, '{2'sd0, 2'sd1}
  };
  localparam step_t ORDER8 [8] = '{
    '{2'sd1, 2'sd0}, '{2'sd0, -2'sd1}, '{-2'sd1, 2'sd0}, '{2'sd0, 2'sd1},
    '{-2'sd1, -2'sd1}, '{-2'sd1, 2'sd1}, '{2'sd1, -2'sd1}, '{2'sd1, 2'sd1}
  };

  // straight slots flanking each diagonal slot of the eight-way order
  localparam logic [1:0] DIAG_SIDE_A [4] = '{2'd2, 2'd2, 2'd0, 2'd0};
  localparam logic [1:0] DIAG_SIDE_B [4] = '{2'd1, 2'd3, 2'd1, 2'd3};

  function automatic step_t step_sel(input logic mode8, input logic odd,
                                     input logic [2:0] slot);
    step_t s;
    if (mode8) begin
      s = ORDER8[slot];
    end else if (odd) begin
      s = ORDER_ODD4[slot[1:0]];
    end else begin
      s = ORDER_EVEN4[slot[1:0]];
    end
    return s;
  endfunction

  // one step off the cell; minus one wraps to all ones, which never fits the grid
  function automatic logic [DIM_W-1:0] nbr_coord(input logic [COORD_W-1:0] c,
                                                 input logic signed [1:0] d);
    return {1'b0, c} + {{(DIM_W-2){d[1]}}, d};
  endfunction

endpackage

// ----- rtl/gne_channels.sv -----
// gne_channels: valid/ready channel interfaces of the grid neighbour expander
// depends on gne_pkg for field widths
interface gne_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [gne_pkg::COORD_W-1:0] cell_x;
  logic [gne_pkg::COORD_W-1:0] cell_y;
  modport source (output valid, output action, output cell_x, output cell_y, input ready);
  modport sink (input valid, input action, input cell_x, input cell_y, output ready);
endinterface

interface gne_out_if;
  logic                        valid;
  logic                        ready;
  logic [gne_pkg::COORD_W-1:0] next_x;
  logic [gne_pkg::COORD_W-1:0] next_y;
  logic                        has_next;
  logic                        now_blocked;
  logic                        out_of_grid;
  logic                        last;
  modport source (output valid, output next_x, output next_y, output has_next,
                  output now_blocked, output out_of_grid, output last, input ready);
  modport sink (input valid, input next_x, input next_y, input has_next,
                input now_blocked, input out_of_grid, input last, output ready);
endinterface

interface gne_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gne_pkg::CFG_IDX_W-1:0] index;
  logic [gne_pkg::DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/gne_map.sv -----
// gne_map: single-port blocked-bit memory, one bit per cell, registered read
// no dependencies
module gne_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic          wdata,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/gne_nbr.sv -----
// gne_nbr: map clearing sweep, request decode, toggle read-modify-write and neighbour scan
// depends on gne_pkg; drives gne_map and hands finished jobs to gne_out
module gne_nbr #(
  parameter int MAX_WIDTH  = 64,
  parameter int DEPTH      = 4096,
  parameter int AW         = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gne_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [gne_pkg::COORD_W-1:0] in_x,
  input  logic [gne_pkg::COORD_W-1:0] in_y,
  output logic                        job_valid,
  input  logic                        job_ready,
  output gne_pkg::job_t               job,
  output logic                        map_en,
  output logic                        map_we,
  output logic [AW-1:0]               map_addr,
  output logic                        map_wdata,
  input  logic                        map_rdata
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_TOGGLE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_HAND   = 3'd4;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] addr_of(input logic [gne_pkg::DIM_W-1:0] ax,
                                            input logic [gne_pkg::DIM_W-1:0] ay);
    return AW'(32'(ay) * 32'(MAX_WIDTH) + 32'(ax));
  endfunction

  logic [2:0]                  state_r, state_nxt;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic [gne_pkg::COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic                        mode_r, mode_nxt, odd_r, odd_nxt;
  logic [3:0]                  slot_r, slot_nxt;
  logic                        pend_r, pend_nxt, pinb_r, pinb_nxt;
  logic [2:0]                  pslot_r, pslot_nxt;
  logic [gne_pkg::NSLOT-1:0]   mask_r, mask_nxt, mask_upd;
  gne_pkg::job_t               job_r, job_nxt;

  gne_pkg::step_t              cur_step;
  logic [gne_pkg::DIM_W-1:0]   px, py;
  logic                        slot_inb, cell_inb, issue, accept, corner_ok, opn;
  logic [3:0]                  last_slot;
  logic [1:0]                  dslot;

  always_comb begin
    cur_step  = gne_pkg::step_sel(mode_r, odd_r, slot_r[2:0]);
    px        = gne_pkg::nbr_coord(x_r, cur_step.dx);
    py        = gne_pkg::nbr_coord(y_r, cur_step.dy);
    slot_inb  = (px < cfg.width) && (py < cfg.height);
    cell_inb  = ({1'b0, in_x} < cfg.width) && ({1'b0, in_y} < cfg.height);
    last_slot = mode_r ? 4'd7 : 4'd3;
    issue     = (state_r == S_SCAN) && (slot_r <= last_slot);
    in_ready  = (state_r == S_IDLE);
    accept    = in_valid && in_ready;
    dslot     = pslot_r[1:0];
    corner_ok = !(mode_r && pslot_r[2]) ||
                (mask_r[{1'b0, gne_pkg::DIAG_SIDE_A[dslot]}] &&
                 mask_r[{1'b0, gne_pkg::DIAG_SIDE_B[dslot]}]);
    opn       = pinb_r && !map_rdata && corner_ok;
    mask_upd  = mask_r | (gne_pkg::NSLOT'(opn) << pslot_r);
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    addr_nxt     = addr_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    mode_nxt     = mode_r;
    odd_nxt      = odd_r;
    slot_nxt     = slot_r;
    pend_nxt     = pend_r;
    pinb_nxt     = pinb_r;
    pslot_nxt    = pslot_r;
    mask_nxt     = mask_r;
    job_nxt      = job_r;
    map_en       = 1'b0;
    map_we       = 1'b0;
    map_addr     = '0;
    map_wdata    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        map_en       = 1'b1;
        map_we       = 1'b1;
        map_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          job_nxt = '0;
          if (!cell_inb) begin
            job_nxt.out_of_grid = 1'b1;
            state_nxt           = S_HAND;
          end else if (in_action == gne_pkg::ACT_TOGGLE) begin
            map_en    = 1'b1;
            map_addr  = addr_of({1'b0, in_x}, {1'b0, in_y});
            addr_nxt  = map_addr;
            state_nxt = S_TOGGLE;
          end else begin
            x_nxt     = in_x;
            y_nxt     = in_y;
            mode_nxt  = cfg.mode8;
            odd_nxt   = in_x[0] ^ in_y[0];
            slot_nxt  = '0;
            pend_nxt  = 1'b0;
            mask_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_TOGGLE: begin
        map_en              = 1'b1;
        map_we              = 1'b1;
        map_addr            = addr_r;
        map_wdata           = !map_rdata;
        job_nxt.now_blocked = !map_rdata;
        state_nxt           = S_HAND;
      end
      S_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          map_en    = slot_inb;
          map_addr  = addr_of(px, py);
          slot_nxt  = slot_r + 4'd1;
          pslot_nxt = slot_r[2:0];
          pinb_nxt  = slot_inb;
        end
        if (pend_r) begin
          mask_nxt = mask_upd;
          if (pslot_r == last_slot[2:0]) begin
            job_nxt.x         = x_r;
            job_nxt.y         = y_r;
            job_nxt.mode8     = mode_r;
            job_nxt.odd       = odd_r;
            job_nxt.open_mask = mask_upd;
            state_nxt         = S_HAND;
          end
        end
      end
      S_HAND: begin
        if (job_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign job_valid = (state_r == S_HAND);
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    mode_r  <= mode_nxt;
    odd_r   <= odd_nxt;
    slot_r  <= slot_nxt;
    pinb_r  <= pinb_nxt;
    pslot_r <= pslot_nxt;
    mask_r  <= mask_nxt;
    job_r   <= job_nxt;
  end

endmodule

// ----- rtl/gne_out.sv -----
// gne_out: result emitter, walks the open-neighbour mask of a job into registered results
// depends on gne_pkg
module gne_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  gne_pkg::job_t               job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gne_pkg::COORD_W-1:0] out_next_x,
  output logic [gne_pkg::COORD_W-1:0] out_next_y,
  output logic                        out_has_next,
  output logic                        out_now_blocked,
  output logic                        out_out_of_grid,
  output logic                        out_last
);

  logic                        active_r, out_valid_r;
  gne_pkg::job_t               job_r;
  logic [gne_pkg::NSLOT-1:0]   rem_r, rest;
  logic [2:0]                  pick;
  gne_pkg::step_t              st;
  logic [gne_pkg::DIM_W-1:0]   nx, ny;
  logic                        advance;
  logic [gne_pkg::COORD_W-1:0] next_x_r, next_y_r;
  logic                        has_next_r, now_blocked_r, out_of_grid_r, last_r;

  always_comb begin
    pick = '0;
    for (int k = gne_pkg::NSLOT - 1; k >= 0; k--) begin
      if (rem_r[k]) begin
        pick = 3'(k);
      end
    end
    rest    = rem_r & ~(gne_pkg::NSLOT'(1) << pick);
    st      = gne_pkg::step_sel(job_r.mode8, job_r.odd, pick);
    nx      = gne_pkg::nbr_coord(job_r.x, st.dx);
    ny      = gne_pkg::nbr_coord(job_r.y, st.dy);
    advance = active_r && (!out_valid_r || out_ready);
  end

  assign job_ready = !active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (job_valid && job_ready) begin
        active_r <= 1'b1;
      end else if (advance && (rest == '0)) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
      rem_r <= job.open_mask;
    end else if (advance) begin
      rem_r <= rest;
    end
    if (advance) begin
      if (rem_r == '0) begin
        next_x_r      <= '0;
        next_y_r      <= '0;
        has_next_r    <= 1'b0;
        now_blocked_r <= job_r.now_blocked;
        out_of_grid_r <= job_r.out_of_grid;
        last_r        <= 1'b1;
      end else begin
        next_x_r      <= nx[gne_pkg::COORD_W-1:0];
        next_y_r      <= ny[gne_pkg::COORD_W-1:0];
        has_next_r    <= 1'b1;
        now_blocked_r <= 1'b0;
        out_of_grid_r <= 1'b0;
        last_r        <= (rest == '0);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_x      = next_x_r;
  assign out_next_y      = next_y_r;
  assign out_has_next    = has_next_r;
  assign out_now_blocked = now_blocked_r;
  assign out_out_of_grid = out_of_grid_r;
  assign out_last        = last_r;

endmodule

// ----- rtl/grid_neighbour_expander_core.sv -----
// grid_neighbour_expander_core: top level, configuration registers, map, scanner and emitter
// depends on gne_pkg, gne_channels, gne_map, gne_nbr and gne_out
//
//   channel   role   payload                                                  request taken
//   in_chan   sink   action, cell_x, cell_y                                   valid & ready
//   out_chan  source next_x, next_y, has_next, now_blocked, out_of_grid, last valid & ready
//   cfg_chan  sink   index, data                                              valid (ready held high)
//
// a toggle request runs decode with map read, map write and handoff, one outside the grid
// only decode and handoff. an expand scans its neighbour slots in order, one map read per
// slot inside the grid on the single map port. results drain one per cycle from an output
// register while out_chan is ready, overlapping the next request. after reset the map is
// cleared one cell a cycle while in_chan.ready stays low. a stalled out_chan holds the
// current result and, once the emitter holds a job, stops the scanner at handoff.
module grid_neighbour_expander_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input logic      clk,
  input logic      rst_n,
  gne_in_if.sink   in_chan,
  gne_out_if.source out_chan,
  gne_cfg_if.sink  cfg_chan
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int W_CAP = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int H_CAP = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

  logic [gne_pkg::DIM_W-1:0] grid_width_r, grid_height_r;
  logic                      move_mode_r;
  gne_pkg::cfg_t             cfg;

  logic          job_valid, job_ready;
  gne_pkg::job_t job;
  logic          map_en, map_we, map_wdata, map_rdata;
  logic [AW-1:0] map_addr;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= gne_pkg::GRID_DIM_RESET;
      grid_height_r <= gne_pkg::GRID_DIM_RESET;
      move_mode_r   <= gne_pkg::MOVE_MODE_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        gne_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_chan.data;
        gne_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_chan.data;
        gne_pkg::REG_MOVE_MODE:   move_mode_r   <= cfg_chan.data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.width  = (grid_width_r > gne_pkg::DIM_W'(W_CAP)) ? gne_pkg::DIM_W'(W_CAP)
                                                         : grid_width_r;
    cfg.height = (grid_height_r > gne_pkg::DIM_W'(H_CAP)) ? gne_pkg::DIM_W'(H_CAP)
                                                          : grid_height_r;
    cfg.mode8  = move_mode_r;
  end

  gne_map #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .en    (map_en),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  gne_nbr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_nbr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_action (in_chan.action),
    .in_x      (in_chan.cell_x),
    .in_y      (in_chan.cell_y),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .map_en    (map_en),
    .map_we    (map_we),
    .map_addr  (map_addr),
    .map_wdata (map_wdata),
    .map_rdata (map_rdata)
  );

  gne_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_next_x      (out_chan.next_x),
    .out_next_y      (out_chan.next_y),
    .out_has_next    (out_chan.has_next),
    .out_now_blocked (out_chan.now_blocked),
    .out_out_of_grid (out_chan.out_of_grid),
    .out_last        (out_chan.last)
  );

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while previous one still in work");

  a_empty_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.has_next |-> out_chan.last)
    else $error("result without neighbour not marked last");

  a_neighbour_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.has_next |-> !out_chan.now_blocked && !out_chan.out_of_grid)
    else $error("neighbour result carries toggle or out of grid flag");

  a_no_map_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> !map_we)
    else $error("map written while a job waits for handoff");

endmodule
